[sv/lfp_pkg.sv]
// ============================================================================
// lfp_pkg
// Shared types, widths and constants of the line-follower PID steering block.
// ============================================================================
package lfp_pkg;

    // Field and datapath widths
    localparam int SUM_BITS  = 24;                    // integral accumulator
    localparam int GAIN_W    = 16;                    // Q8.8 gain
    localparam int BRIGHT_W  = 7;                     // sensor sample
    localparam int ERR_W     = BRIGHT_W + 1;          // left minus right
    localparam int DIFF_W    = ERR_W + 1;             // error difference
    localparam int PROD_P_W  = GAIN_W + ERR_W;
    localparam int PROD_I_W  = GAIN_W + SUM_BITS;
    localparam int PROD_D_W  = GAIN_W + DIFF_W;
    localparam int ACC_W     = PROD_I_W + 2;          // sum of three products
    localparam int FRAC_W    = 8;                     // Q8.8 fraction bits
    localparam int TRUNC_W   = ACC_W - FRAC_W;
    localparam int CORR_W    = 11;                    // clamped correction
    localparam int SPEED_W   = 8;
    localparam int SPD_SUM_W = CORR_W + 1;            // base +/- correction
    localparam int ANGLE_W   = 7;
    localparam int ANG_REG_W = 6;
    localparam int THR_W     = 7;

    // Limits
    localparam int CORR_MAX_I  = (1 << (CORR_W - 1)) - 1;
    localparam int SPEED_LIMIT = 100;
    localparam logic [ANG_REG_W-1:0] ANGLE_LIMIT = ANG_REG_W'(55);

    localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
    localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P      = 4'd0,
        REG_GAIN_I      = 4'd1,
        REG_GAIN_D      = 4'd2,
        REG_BASE_LEFT   = 4'd3,
        REG_BASE_RIGHT  = 4'd4,
        REG_STEER_THR   = 4'd5,
        REG_RIGHT_ANGLE = 4'd6,
        REG_LEFT_ANGLE  = 4'd7
    } t_reg_idx;

    // Turn direction codes
    typedef enum logic [1:0] {
        DIR_STRAIGHT = 2'd0,
        DIR_LEFT     = 2'd1,
        DIR_RIGHT    = 2'd2
    } t_dir;

    typedef struct packed {
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic signed [SPEED_W-1:0] base_left;
        logic signed [SPEED_W-1:0] base_right;
        logic [THR_W-1:0]          steer_thr;
        logic [ANG_REG_W-1:0]      right_angle;
        logic [ANG_REG_W-1:0]      left_angle;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        gain_p:      GAIN_W'(26),
        gain_i:      '0,
        gain_d:      '0,
        base_left:   SPEED_W'(20),
        base_right:  SPEED_W'(20),
        steer_thr:   THR_W'(10),
        right_angle: ANG_REG_W'(20),
        left_angle:  ANG_REG_W'(24)
    };

    // Steering result carried down the pipe
    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        t_dir                      dir;
    } t_steer;

    // Front stage payload
    typedef struct packed {
        logic signed [ERR_W-1:0]    err;
        logic signed [DIFF_W-1:0]   diff;
        logic signed [SUM_BITS-1:0] sum;
    } t_front;

    // Product stage payload
    typedef struct packed {
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
        t_steer                     steer;
    } t_prod;

    // Correction stage payload
    typedef struct packed {
        logic signed [CORR_W-1:0] corr;
        t_steer                   steer;
    } t_corr;

    // Result payload
    typedef struct packed {
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [SPEED_W-1:0] left_speed;
        t_steer                    steer;
    } t_result;

endpackage

[sv/lfp_front.sv]
// ============================================================================
// lfp_front
// Error, saturating integral and error difference; holds the loop state.
// ============================================================================
module lfp_front import lfp_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [BRIGHT_W-1:0] i_left,
    input  logic [BRIGHT_W-1:0] i_right,
    output logic                o_valid,
    input  logic                i_ready,
    output t_front              o_data
);

    logic                       r_valid;
    t_front                     r_data;
    logic signed [SUM_BITS-1:0] r_error_sum;
    logic signed [ERR_W-1:0]    r_prev_error;

    logic signed [ERR_W-1:0]    n_err;
    logic [SUM_BITS:0]          n_sum_wide;
    logic signed [SUM_BITS-1:0] n_sum;
    logic signed [DIFF_W-1:0]   n_diff;
    logic                       accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Error, integral with saturation, difference
    always_comb begin
        n_err      = $signed({1'b0, i_left}) - $signed({1'b0, i_right});
        n_sum_wide = {r_error_sum[SUM_BITS-1], r_error_sum}
                   + {{(SUM_BITS+1-ERR_W){n_err[ERR_W-1]}}, n_err};
        if (n_sum_wide[SUM_BITS] != n_sum_wide[SUM_BITS-1]) begin
            n_sum = n_sum_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
        end else begin
            n_sum = n_sum_wide[SUM_BITS-1:0];
        end
        n_diff = {n_err[ERR_W-1], n_err} - {r_prev_error[ERR_W-1], r_prev_error};
    end

    // Loop state and stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_error_sum  <= '0;
            r_prev_error <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_error_sum  <= n_sum;
                r_prev_error <= n_err;
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data.err  <= n_err;
            r_data.diff <= n_diff;
            r_data.sum  <= n_sum;
        end
    end

endmodule

[sv/lfp_products.sv]
// ============================================================================
// lfp_products
// Gain products and steering decision, one register stage.
// ============================================================================
module lfp_products import lfp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_front i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_prod  o_data
);

    logic  r_valid;
    t_prod r_data;

    logic signed [PROD_P_W-1:0]  n_prod_p;
    logic signed [PROD_I_W-1:0]  n_prod_i;
    logic signed [PROD_D_W-1:0]  n_prod_d;
    logic signed [ERR_W:0]       err_x;
    logic signed [ERR_W:0]       thr_x;
    logic [ANG_REG_W-1:0]        right_lim;
    logic [ANG_REG_W-1:0]        left_lim;
    t_steer                      n_steer;
    logic                        accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Three gain products
    always_comb begin
        n_prod_p = i_cfg.gain_p * i_data.err;
        n_prod_i = i_cfg.gain_i * i_data.sum;
        n_prod_d = i_cfg.gain_d * i_data.diff;
    end

    // Steering: threshold on the error, angle limited, zero angle is straight
    always_comb begin
        err_x     = {i_data.err[ERR_W-1], i_data.err};
        thr_x     = $signed({{(ERR_W+1-THR_W){1'b0}}, i_cfg.steer_thr});
        right_lim = (i_cfg.right_angle > ANGLE_LIMIT) ? ANGLE_LIMIT : i_cfg.right_angle;
        left_lim  = (i_cfg.left_angle > ANGLE_LIMIT) ? ANGLE_LIMIT : i_cfg.left_angle;
        n_steer.angle = '0;
        n_steer.dir   = DIR_STRAIGHT;
        if (err_x > thr_x) begin
            if (right_lim != '0) begin
                n_steer.angle = $signed({1'b0, right_lim});
                n_steer.dir   = DIR_RIGHT;
            end
        end else if (err_x < -thr_x) begin
            if (left_lim != '0) begin
                n_steer.angle = -$signed({1'b0, left_lim});
                n_steer.dir   = DIR_LEFT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data.prod_p <= n_prod_p;
            r_data.prod_i <= n_prod_i;
            r_data.prod_d <= n_prod_d;
            r_data.steer  <= n_steer;
        end
    end

endmodule

[sv/lfp_correct.sv]
// ============================================================================
// lfp_correct
// Sums the products, truncates toward zero to whole percent and clamps.
// Two register stages: accumulate, then scale and clamp.
// ============================================================================
module lfp_correct import lfp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_prod i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_corr o_data
);

    localparam logic signed [TRUNC_W-1:0] CORR_HI = TRUNC_W'(CORR_MAX_I);
    localparam logic signed [TRUNC_W-1:0] CORR_LO = -CORR_HI - TRUNC_W'(1);

    // Accumulate stage
    logic                    r_acc_valid;
    logic signed [ACC_W-1:0] r_acc;
    t_steer                  r_acc_steer;
    logic                    acc_ready;
    logic                    acc_accept;
    logic signed [ACC_W-1:0] ext_p;
    logic signed [ACC_W-1:0] ext_i;
    logic signed [ACC_W-1:0] ext_d;
    logic signed [ACC_W-1:0] n_acc;

    // Scale stage
    logic                      r_valid;
    t_corr                     r_data;
    logic                      corr_accept;
    logic signed [TRUNC_W-1:0] floor_val;
    logic                      round_up;
    logic signed [TRUNC_W-1:0] n_trunc;
    logic signed [CORR_W-1:0]  n_corr;

    // Accumulate stage takes a new item when empty or when the scale stage moves
    assign acc_ready  = !r_acc_valid || !r_valid || i_ready;
    assign acc_accept = i_valid && acc_ready;
    assign o_ready    = acc_ready;

    assign corr_accept = r_acc_valid && (!r_valid || i_ready);
    assign o_valid     = r_valid;
    assign o_data      = r_data;

    // Sum of the three products
    always_comb begin
        ext_p = i_data.prod_p;
        ext_i = i_data.prod_i;
        ext_d = i_data.prod_d;
        n_acc = ext_p + ext_i + ext_d;
    end

    // Divide by 256 toward zero, then clamp to the correction range
    always_comb begin
        floor_val = r_acc[ACC_W-1:FRAC_W];
        round_up  = r_acc[ACC_W-1] && (|r_acc[FRAC_W-1:0]);
        n_trunc   = floor_val + $signed({{(TRUNC_W-1){1'b0}}, round_up});
        if (n_trunc > CORR_HI) begin
            n_corr = CORR_HI[CORR_W-1:0];
        end else if (n_trunc < CORR_LO) begin
            n_corr = CORR_LO[CORR_W-1:0];
        end else begin
            n_corr = n_trunc[CORR_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_valid <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            if (acc_ready) begin
                r_acc_valid <= i_valid;
            end
            if (!r_valid || i_ready) begin
                r_valid <= r_acc_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_accept) begin
            r_acc       <= n_acc;
            r_acc_steer <= i_data.steer;
        end
        if (corr_accept) begin
            r_data.corr  <= n_corr;
            r_data.steer <= r_acc_steer;
        end
    end

endmodule

[sv/lfp_drive.sv]
// ============================================================================
// lfp_drive
// Adds the correction to the base speeds, saturates, holds the result.
// ============================================================================
module lfp_drive import lfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_corr   i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    localparam logic signed [SPD_SUM_W-1:0] SPD_HI = SPD_SUM_W'(SPEED_LIMIT);
    localparam logic signed [SPD_SUM_W-1:0] SPD_LO = -SPD_HI;

    logic    r_valid;
    t_result r_data;
    logic    accept;

    logic signed [SPD_SUM_W-1:0] corr_x;
    logic signed [SPD_SUM_W-1:0] base_l_x;
    logic signed [SPD_SUM_W-1:0] base_r_x;
    logic signed [SPD_SUM_W-1:0] sum_l;
    logic signed [SPD_SUM_W-1:0] sum_r;
    logic signed [SPEED_W-1:0]   n_left;
    logic signed [SPEED_W-1:0]   n_right;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Left gets base plus correction, right base minus correction
    always_comb begin
        corr_x   = i_data.corr;
        base_l_x = i_cfg.base_left;
        base_r_x = i_cfg.base_right;
        sum_l    = base_l_x + corr_x;
        sum_r    = base_r_x - corr_x;
        if (sum_l > SPD_HI) begin
            n_left = SPD_HI[SPEED_W-1:0];
        end else if (sum_l < SPD_LO) begin
            n_left = SPD_LO[SPEED_W-1:0];
        end else begin
            n_left = sum_l[SPEED_W-1:0];
        end
        if (sum_r > SPD_HI) begin
            n_right = SPD_HI[SPEED_W-1:0];
        end else if (sum_r < SPD_LO) begin
            n_right = SPD_LO[SPEED_W-1:0];
        end else begin
            n_right = sum_r[SPEED_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data.left_speed  <= n_left;
            r_data.right_speed <= n_right;
            r_data.steer       <= i_data.steer;
        end
    end

endmodule

[sv/line_follow_pid_steering.sv]
// ============================================================================
// line_follow_pid_steering
// PID line follower: steering angle, turn direction and drive speeds from a
// pair of optical brightness samples.
// ============================================================================
//
//  Channel   Direction  Ports                         Moves
//  --------  ---------  ----------------------------  --------------------------
//  s_axis    in         s_axis_tvalid/tready/tdata    one sensor sample pair
//  m_axis    out        m_axis_tvalid/tready/tdata    one steering/speed result
//  cfg       in         i_cfg_valid/o_cfg_ready/...   one register write request
//
//  One sample is accepted per cycle while the output is not stalled; its result
//  passes the front, products, accumulate, scale and drive register stages.
//  The integral and the previous error update at the moment a sample is
//  accepted, so the loop state never waits on the later stages.
//  Each stage holds its item while the next one is full; a stalled output
//  backs up stage by stage, and empty stages keep taking samples.
//  Synchronous active-low reset clears the loop state and loads the
//  register defaults; configuration writes are always taken.
//
module line_follow_pid_steering import lfp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Sample input; tdata: [6:0] left_brightness, [13:7] right_brightness
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,
    // Result output; tdata: [6:0] steer_angle, [8:7] turn_direction,
    // [16:9] left_speed, [24:17] right_speed
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,
    // Register write port
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    r_cfg;
    logic    front_valid, front_ready;
    t_front  front_data;
    logic    prod_valid, prod_ready;
    t_prod   prod_data;
    logic    corr_valid, corr_ready;
    t_corr   corr_data;
    t_result result;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_GAIN_P:      r_cfg.gain_p      <= i_cfg_data;
                REG_GAIN_I:      r_cfg.gain_i      <= i_cfg_data;
                REG_GAIN_D:      r_cfg.gain_d      <= i_cfg_data;
                REG_BASE_LEFT:   r_cfg.base_left   <= i_cfg_data[SPEED_W-1:0];
                REG_BASE_RIGHT:  r_cfg.base_right  <= i_cfg_data[SPEED_W-1:0];
                REG_STEER_THR:   r_cfg.steer_thr   <= i_cfg_data[THR_W-1:0];
                REG_RIGHT_ANGLE: r_cfg.right_angle <= i_cfg_data[ANG_REG_W-1:0];
                REG_LEFT_ANGLE:  r_cfg.left_angle  <= i_cfg_data[ANG_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline
    lfp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_left  (s_axis_tdata[BRIGHT_W-1:0]),
        .i_right (s_axis_tdata[2*BRIGHT_W-1:BRIGHT_W]),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_data  (front_data)
    );

    lfp_products u_products (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_data  (front_data),
        .o_valid (prod_valid),
        .i_ready (prod_ready),
        .o_data  (prod_data)
    );

    lfp_correct u_correct (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .o_ready (prod_ready),
        .i_data  (prod_data),
        .o_valid (corr_valid),
        .i_ready (corr_ready),
        .o_data  (corr_data)
    );

    lfp_drive u_drive (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (corr_valid),
        .o_ready (corr_ready),
        .i_data  (corr_data),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (result)
    );

    assign m_axis_tdata = {7'b0, result.right_speed, result.left_speed,
                           result.steer.dir, result.steer.angle};

`ifndef ASSERT_OFF
    // Nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // Straight exactly when the angle is zero
    a_dir_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((result.steer.dir == DIR_STRAIGHT) ==
                           (result.steer.angle == '0)))
        else $error("turn direction disagrees with steering angle");

    // Speeds and angle stay within their limits
    a_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((result.left_speed <= 8'sd100)
                        && (result.left_speed >= -8'sd100)
                        && (result.right_speed <= 8'sd100)
                        && (result.right_speed >= -8'sd100)
                        && (result.steer.angle <= 7'sd55)
                        && (result.steer.angle >= -7'sd55)))
        else $error("result outside saturation limits");
`endif

endmodule

[sim/steer_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// steer_checker
// Watches the sample, result and register channels of the PID steering block.
// It keeps its own copy of the gains and loop state, predicts the steering
// command for every accepted sample and compares each result field by field.
// ============================================================================
module steer_checker import lfp_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // tdata: [6:0] left_brightness, [13:7] right_brightness
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,
    // tdata: [6:0] steer_angle, [8:7] turn_direction,
    // [16:9] left_speed, [24:17] right_speed
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [31:0]           m_axis_tdata,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int DIR_LSB   = ANGLE_W;
    localparam int LEFT_LSB  = ANGLE_W + 2;
    localparam int RIGHT_LSB = LEFT_LSB + SPEED_W;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] angle;
        t_dir                      dir;
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
    } t_steer_cmd;

    t_cfg       cfg_shadow = CFG_RESET;
    longint     integral   = 0;
    longint     last_err   = 0;
    t_steer_cmd cmd_expect_q[$];
    int         mismatches = 0;

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // One PID step: updates the integral and last error, returns the command
    function automatic t_steer_cmd predict_cmd(logic [BRIGHT_W-1:0] left_b,
                                               logic [BRIGHT_W-1:0] right_b);
        longint     err, diff, acc, corr, lim, thr, ang;
        t_steer_cmd cmd;
        lim      = (longint'(1) << (SUM_BITS - 1)) - 1;
        err      = longint'(left_b) - longint'(right_b);
        integral = clip(integral + err, -lim - 1, lim);
        diff     = err - last_err;
        last_err = err;

        acc  = longint'($signed(cfg_shadow.gain_p)) * err
             + longint'($signed(cfg_shadow.gain_i)) * integral
             + longint'($signed(cfg_shadow.gain_d)) * diff;
        corr = acc / 256;     // Q8.8 to whole percent, toward zero

        cmd.left_speed  = SPEED_W'(clip(longint'($signed(cfg_shadow.base_left)) + corr,
                                        -SPEED_LIMIT, SPEED_LIMIT));
        cmd.right_speed = SPEED_W'(clip(longint'($signed(cfg_shadow.base_right)) - corr,
                                        -SPEED_LIMIT, SPEED_LIMIT));

        // steering select, angle registers capped at the mechanical limit
        thr = longint'(cfg_shadow.steer_thr);
        if (err > thr) begin
            ang     = (cfg_shadow.right_angle > ANGLE_LIMIT) ? ANGLE_LIMIT
                                                             : cfg_shadow.right_angle;
            cmd.dir = DIR_RIGHT;
        end else if (err < -thr) begin
            ang     = (cfg_shadow.left_angle > ANGLE_LIMIT) ? ANGLE_LIMIT
                                                            : cfg_shadow.left_angle;
            ang     = -ang;
            cmd.dir = DIR_LEFT;
        end else begin
            ang     = 0;
            cmd.dir = DIR_STRAIGHT;
        end
        // a zero turn angle means straight ahead
        if (ang == 0)
            cmd.dir = DIR_STRAIGHT;
        cmd.angle = ANGLE_W'(ang);
        return cmd;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Track register writes, queue predictions, compare results
    always @(posedge i_clk) begin : monitor
        t_steer_cmd got;
        t_steer_cmd want;
        if (!i_rst_n) begin
            cfg_shadow = CFG_RESET;
            integral   = 0;
            last_err   = 0;
            cmd_expect_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_GAIN_P:      cfg_shadow.gain_p      = i_cfg_data;
                    REG_GAIN_I:      cfg_shadow.gain_i      = i_cfg_data;
                    REG_GAIN_D:      cfg_shadow.gain_d      = i_cfg_data;
                    REG_BASE_LEFT:   cfg_shadow.base_left   = i_cfg_data[SPEED_W-1:0];
                    REG_BASE_RIGHT:  cfg_shadow.base_right  = i_cfg_data[SPEED_W-1:0];
                    REG_STEER_THR:   cfg_shadow.steer_thr   = i_cfg_data[THR_W-1:0];
                    REG_RIGHT_ANGLE: cfg_shadow.right_angle = i_cfg_data[ANG_REG_W-1:0];
                    REG_LEFT_ANGLE:  cfg_shadow.left_angle  = i_cfg_data[ANG_REG_W-1:0];
                    default: ;       // unmapped index, dropped
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
                cmd_expect_q.push_back(predict_cmd(s_axis_tdata[BRIGHT_W-1:0],
                                                   s_axis_tdata[2*BRIGHT_W-1:BRIGHT_W]));

            if (m_axis_tvalid && m_axis_tready) begin
                got.angle       = m_axis_tdata[ANGLE_W-1:0];
                got.dir         = t_dir'(m_axis_tdata[DIR_LSB+:2]);
                got.left_speed  = m_axis_tdata[LEFT_LSB+:SPEED_W];
                got.right_speed = m_axis_tdata[RIGHT_LSB+:SPEED_W];
                if (cmd_expect_q.size() == 0) begin
                    $error("result with no request pending: tdata %h", m_axis_tdata);
                    mismatches++;
                end else begin
                    want = cmd_expect_q.pop_front();
                    check_field("steer_angle", want.angle, got.angle);
                    check_field("turn_direction", want.dir, got.dir);
                    check_field("left_speed", want.left_speed, got.left_speed);
                    check_field("right_speed", want.right_speed, got.right_speed);
                end
            end
        end
        o_pending    <= cmd_expect_q.size();
        o_fail_count <= mismatches;
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb
// Testbench for the PID line-follower steering block. Drives sensor samples
// and register writes with random gaps and result stalls, including one long
// output hold-off; the checker predicts and compares every result.
// ============================================================================
module tb;
    import lfp_pkg::*;

    localparam int ITEMS_PER_PHASE = 85;
    localparam int PHASES          = 8;
    localparam int PRESSURE_PHASE  = 3;
    localparam int LONG_HOLD       = 60;
    localparam int DRAIN_CYCLES    = 12;
    localparam int REG_COUNT       = 8;
    localparam int LIMIT           = 100000;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int                    fail_count;
    int                    pending;
    int                    cycles        = 0;
    bit                    no_idle       = 1'b0;
    bit                    hold_req      = 1'b0;
    logic [THR_W-1:0]      thr_now       = CFG_RESET.steer_thr;

    line_follow_pid_steering dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    steer_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin : result_sink
        int stall;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 5);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Offer one sample pair; returns at the edge it is taken
    task automatic send_sample(input logic [BRIGHT_W-1:0] left_b,
                               input logic [BRIGHT_W-1:0] right_b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, right_b, left_b};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic settle;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == REG_STEER_THR)
            thr_now = value[THR_W-1:0];
        @(posedge i_clk);
    endtask

    // Random register value, biased toward the ends of each range
    function automatic logic [CFG_DATA_W-1:0] pick_setting(t_reg_idx idx);
        logic [CFG_DATA_W-1:0] v;
        int                    w;
        int                    roll;
        roll = $urandom_range(0, 7);
        case (idx)
            REG_GAIN_P, REG_GAIN_D, REG_GAIN_I: begin
                w = GAIN_W;
                case (roll)
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = '0;
                    3:       v = CFG_DATA_W'($urandom);
                    default: begin
                        // keep the integral gain small so speeds move
                        if (idx == REG_GAIN_I)
                            v = CFG_DATA_W'(int'($urandom_range(0, 48)) - 24);
                        else
                            v = CFG_DATA_W'(int'($urandom_range(0, 1200)) - 600);
                    end
                endcase
            end
            REG_BASE_LEFT, REG_BASE_RIGHT: begin
                w = SPEED_W;
                case (roll)
                    0:       v = CFG_DATA_W'(-SPEED_LIMIT);
                    1:       v = CFG_DATA_W'(SPEED_LIMIT);
                    2:       v = CFG_DATA_W'($urandom_range(0, 255));
                    default: v = CFG_DATA_W'(int'($urandom_range(0, 200)) - 100);
                endcase
            end
            REG_STEER_THR: begin
                w = THR_W;
                case (roll)
                    0:       v = '0;
                    1:       v = 16'd100;
                    2:       v = 16'd127;
                    default: v = CFG_DATA_W'($urandom_range(0, 100));
                endcase
            end
            default: begin
                w = ANG_REG_W;
                case (roll)
                    0:       v = '0;
                    1:       v = 16'd55;
                    2:       v = 16'd63;
                    default: v = CFG_DATA_W'($urandom_range(0, 55));
                endcase
            end
        endcase
        // junk above the register width now and then
        if (w < CFG_DATA_W && $urandom_range(0, 3) == 0)
            v = v | (CFG_DATA_W'($urandom) << w);
        return v;
    endfunction

    task automatic send_random_sample;
        logic [BRIGHT_W-1:0] l;
        logic [BRIGHT_W-1:0] r;
        int                  roll;
        int                  offs;
        int                  t;
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
            l = BRIGHT_W'($urandom_range(0, 100));
            r = BRIGHT_W'($urandom_range(0, 100));
        end else if (roll < 8) begin
            l = BRIGHT_W'($urandom);
            r = BRIGHT_W'($urandom);
        end else begin
            // error right at the steering threshold, either sign
            r    = BRIGHT_W'($urandom_range(0, 100));
            offs = int'(thr_now) + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(0, 1) == 1)
                offs = -offs;
            t = int'(r) + offs;
            if (t < 0)   t = 0;
            if (t > 127) t = 127;
            l = BRIGHT_W'(t);
        end
        send_sample(l, r);
    endtask

    // Stimulus
    initial begin : stimulus
        int phase;
        int k;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: field extremes, threshold edges both ways
        send_sample(7'd0, 7'd0);
        send_sample(7'd100, 7'd0);
        send_sample(7'd0, 7'd100);
        send_sample(7'd127, 7'd0);
        send_sample(7'd0, 7'd127);
        send_sample(7'd127, 7'd127);
        send_sample(7'd10, 7'd0);
        send_sample(7'd11, 7'd0);
        send_sample(7'd0, 7'd10);
        send_sample(7'd0, 7'd11);
        send_sample(7'd45, 7'd52);
        settle;

        // zero right angle goes straight, oversized left angle is capped
        write_reg(REG_RIGHT_ANGLE, 16'd0);
        write_reg(REG_LEFT_ANGLE, 16'd63);
        send_sample(7'd60, 7'd0);
        send_sample(7'd0, 7'd60);
        settle;

        // extreme gains, out-of-range base, zero threshold
        write_reg(REG_GAIN_P, 16'h8000);
        write_reg(REG_GAIN_I, 16'h7FFF);
        write_reg(REG_GAIN_D, 16'h7FFF);
        write_reg(REG_BASE_LEFT, 16'hFF9C);
        write_reg(REG_BASE_RIGHT, 16'h007F);
        write_reg(REG_STEER_THR, 16'd0);
        write_reg(REG_RIGHT_ANGLE, 16'd55);
        write_reg(REG_LEFT_ANGLE, 16'd55);
        write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        send_sample(7'd127, 7'd0);
        send_sample(7'd0, 7'd127);
        send_sample(7'd64, 7'd64);
        send_sample(7'd1, 7'd0);
        send_sample(7'd0, 7'd1);
        settle;

        // opposite gain signs, threshold beyond any error
        write_reg(REG_GAIN_P, 16'h7FFF);
        write_reg(REG_GAIN_I, 16'h8000);
        write_reg(REG_GAIN_D, 16'h8000);
        write_reg(REG_BASE_LEFT, 16'h0080);
        write_reg(REG_BASE_RIGHT, 16'hFF80);
        write_reg(REG_STEER_THR, 16'h007F);
        send_sample(7'd127, 7'd0);
        send_sample(7'd0, 7'd127);
        send_sample(7'd0, 7'd0);
        settle;

        // random phases, each under a new mix of settings
        for (phase = 0; phase < PHASES; phase++) begin
            for (k = 0; k < REG_COUNT; k++) begin
                if ($urandom_range(0, 3) != 0)
                    write_reg(t_reg_idx'(k), pick_setting(t_reg_idx'(k)));
            end
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)),
                          CFG_DATA_W'($urandom));
            if (phase == PRESSURE_PHASE)
                hold_req = 1'b1;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 20 == 0)
                    no_idle = (phase == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
                send_random_sample;
            end
            no_idle = 1'b0;
            settle;
        end

        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
sv/lfp_pkg.sv
sv/lfp_front.sv
sv/lfp_products.sv
sv/lfp_correct.sv
sv/lfp_drive.sv
sv/line_follow_pid_steering.sv
sim/steer_checker.sv
sim/tb.sv
